FILE: rtl/pip_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the point-in-polygon block.
// No dependencies; every other file imports this package.
package pip_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MIN_VERTS    = 3;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int TCNT_W       = $clog2(QDEPTH + 2);

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEST   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DROP = 2'd1,
    ST_FEW  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_DRAIN
  } back_state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
  } in_word_t;

  typedef struct packed {
    logic             inside_res;
    logic [1:0]       status;
    logic [CNT_W-1:0] vertex_count;
  } out_word_t;

  typedef struct packed {
    logic               walk;
    logic [1:0]         status;
    logic [CNT_W-1:0]   count;
    logic signed [31:0] px;
    logic signed [31:0] py;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       x;
    logic [31:0]       y;
  } wr_t;

  typedef struct packed {
    logic walking;
    logic walk_done;
  } bk_stat_t;

endpackage

FILE: rtl/point_in_polygon_test.sv
`timescale 1ns / 1ps
// Point-in-polygon ray-casting block, top level.
// Depends on pip_pkg, pip_front, pip_fifo and pip_back.
//
// Clear, append and unused commands pass the front-end holding register and the
// job queue into the result register. A test walks the polygon in the back end:
// the vertex memory delivers one vertex per cycle (n + 1 reads for a polygon of
// n vertices, the last vertex first as the closing edge), followed by the
// difference, multiply and compare stages. Clear and append wait in the front
// end until all earlier tests have finished walking; other words queue behind a
// test in a four-entry job queue. The vertex memory is not cleared at reset and
// needs no clearing pass.
module point_in_polygon_test import pip_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_word_t  in_word,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_word
);

  logic     q_push, q_full, q_pop, q_empty;
  job_t     q_wdata, q_rdata;
  wr_t      wr;
  bk_stat_t bk_stat;

  pip_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_word (in_word),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .wr      (wr),
    .bk_stat (bk_stat)
  );

  pip_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_empty (q_empty)
  );

  pip_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .q_empty  (q_empty),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .bk_stat  (bk_stat),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

  a_no_write_walk: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> !bk_stat.walking)
    else $error("vertex write during edge walk");

  a_done_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.walk_done |-> bk_stat.walking)
    else $error("walk finished outside a walk");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job popped from empty queue");

endmodule

FILE: rtl/pip_front.sv
`timescale 1ns / 1ps
// Front end: input holding stage, vertex count, command classification.
// Depends on pip_pkg; feeds pip_fifo and writes the vertex memory in pip_back.
module pip_front import pip_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_word_t in_word,
  input  logic     q_full,
  output logic     q_push,
  output job_t     q_data,
  output wr_t      wr,
  input  bk_stat_t bk_stat
);

  logic              hold_v_r, hold_v_nxt;
  in_word_t          hold_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TCNT_W-1:0] tests_r, tests_nxt;
  logic              needs_mem, adv, accept, has_room;

  always_comb begin
    needs_mem  = (hold_r.command == CMD_CLEAR) || (hold_r.command == CMD_APPEND);
    adv        = hold_v_r && !q_full && (!needs_mem || (tests_r == '0));
    full       = hold_v_r && !adv;
    accept     = push && !full;
    hold_v_nxt = accept || (hold_v_r && !adv);
    has_room   = count_r < CNT_W'(MAX_VERTICES);

    count_nxt     = count_r;
    q_data        = '0;
    q_data.status = ST_OK;
    q_data.count  = count_r;
    q_data.px     = hold_r.coord_x;
    q_data.py     = hold_r.coord_y;
    wr.en         = 1'b0;
    wr.addr       = count_r[ADDR_W-1:0];
    wr.x          = hold_r.coord_x;
    wr.y          = hold_r.coord_y;

    case (hold_r.command)
      CMD_CLEAR: begin
        count_nxt    = '0;
        q_data.count = '0;
      end
      CMD_APPEND: begin
        if (has_room) begin
          wr.en        = adv;
          count_nxt    = count_r + 1'b1;
          q_data.count = count_r + 1'b1;
        end else begin
          q_data.status = ST_DROP;
        end
      end
      CMD_TEST: begin
        if (count_r < CNT_W'(MIN_VERTS)) begin
          q_data.status = ST_FEW;
        end else begin
          q_data.walk = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (!adv) begin
      count_nxt = count_r;
    end
    q_push = adv;

    tests_nxt = tests_r;
    if (adv && q_data.walk && !bk_stat.walk_done) begin
      tests_nxt = tests_r + 1'b1;
    end else if (!(adv && q_data.walk) && bk_stat.walk_done) begin
      tests_nxt = tests_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      count_r  <= '0;
      tests_r  <= '0;
    end else begin
      hold_v_r <= hold_v_nxt;
      count_r  <= count_nxt;
      tests_r  <= tests_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= in_word;
    end
  end

endmodule

FILE: rtl/pip_fifo.sv
`timescale 1ns / 1ps
// Job queue between front and back end.
// Depends on pip_pkg for job_t and the queue depth.
module pip_fifo import pip_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_push,
  input  job_t q_wdata,
  output logic q_full,
  input  logic q_pop,
  output job_t q_rdata,
  output logic q_empty
);

  job_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  always_comb begin
    q_full   = cnt_r == (QPTR_W + 1)'(QDEPTH);
    q_empty  = cnt_r == '0;
    q_rdata  = q_r[rptr_r];
    do_push  = q_push && !q_full;
    do_pop   = q_pop && !q_empty;
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wptr_r] <= q_wdata;
    end
  end

endmodule

FILE: rtl/pip_back.sv
`timescale 1ns / 1ps
// Back end: vertex memory, edge walk pipeline and result register.
// Depends on pip_pkg; pops jobs from pip_fifo, takes writes from pip_front.
module pip_back import pip_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  wr_t       wr,
  input  logic      q_empty,
  input  job_t      q_rdata,
  output logic      q_pop,
  output bk_stat_t  bk_stat,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_word
);

  logic [63:0] vmem [MAX_VERTICES];

  back_state_t       state_r, state_nxt;
  job_t              job_r;
  logic [CNT_W-1:0]  step_r, step_nxt, cnt_m1, step_m1;
  logic [ADDR_W-1:0] rd_addr;
  logic              iss_v, iss_first, iss_last;
  logic              load_job, load_res, out_v_r, out_v_nxt;
  out_word_t         out_r, res;
  logic              inside_r, inside_nxt;

  logic               s1_v_r, s1_first_r, s1_last_r;
  logic [63:0]        rd_r;
  logic signed [31:0] xi, yi, prev_x_r, prev_y_r;

  logic               s2_v_r, s2_last_r, s2_str_r, s2_dypos_r;
  logic signed [32:0] s2_a_r, s2_dy_r, s2_b_r, s2_c_r;

  logic               s3_v_r, s3_last_r, s3_str_r, s3_dypos_r;
  logic signed [65:0] s3_lhs_r, s3_rhs_r;
  logic               hit, tog, walk_done;

  always_comb begin
    cnt_m1    = job_r.count - 1'b1;
    step_m1   = step_r - 1'b1;
    iss_v     = state_r == BK_WALK;
    iss_first = step_r == '0;
    iss_last  = step_r == job_r.count;
    rd_addr   = iss_first ? cnt_m1[ADDR_W-1:0] : step_m1[ADDR_W-1:0];
    xi        = rd_r[63:32];
    yi        = rd_r[31:0];
    hit       = s3_dypos_r ? (s3_lhs_r < s3_rhs_r) : (s3_rhs_r < s3_lhs_r);
    tog       = s3_v_r && s3_str_r && hit;
    walk_done = s3_v_r && s3_last_r;
  end

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    q_pop      = 1'b0;
    load_job   = 1'b0;
    load_res   = 1'b0;
    inside_nxt = inside_r ^ tog;
    res.inside_res   = 1'b0;
    res.status       = q_rdata.status;
    res.vertex_count = q_rdata.count;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (q_rdata.walk) begin
            if (!out_v_r) begin
              q_pop      = 1'b1;
              load_job   = 1'b1;
              step_nxt   = '0;
              inside_nxt = 1'b0;
              state_nxt  = BK_WALK;
            end
          end else if (!out_v_r || pop) begin
            q_pop    = 1'b1;
            load_res = 1'b1;
          end
        end
      end
      BK_WALK: begin
        step_nxt = step_r + 1'b1;
        if (iss_last) begin
          state_nxt = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (walk_done) begin
          load_res         = 1'b1;
          res.inside_res   = inside_r ^ tog;
          res.status       = ST_OK;
          res.vertex_count = job_r.count;
          state_nxt        = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
    out_v_nxt = load_res || (out_v_r && !pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      s1_v_r  <= iss_v;
      s2_v_r  <= s1_v_r && !s1_first_r;
      s3_v_r  <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      vmem[wr.addr] <= {wr.x, wr.y};
    end
    rd_r <= vmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    inside_r   <= inside_nxt;
    s1_first_r <= iss_first;
    s1_last_r  <= iss_last;
    if (load_job) begin
      job_r <= q_rdata;
    end
    if (load_res) begin
      out_r <= res;
    end
    if (s1_v_r) begin
      prev_x_r <= xi;
      prev_y_r <= yi;
    end
    s2_last_r  <= s1_last_r;
    s2_str_r   <= (yi > job_r.py) != (prev_y_r > job_r.py);
    s2_dypos_r <= prev_y_r > yi;
    s2_a_r     <= {job_r.px[31], job_r.px} - {xi[31], xi};
    s2_dy_r    <= {prev_y_r[31], prev_y_r} - {yi[31], yi};
    s2_b_r     <= {prev_x_r[31], prev_x_r} - {xi[31], xi};
    s2_c_r     <= {job_r.py[31], job_r.py} - {yi[31], yi};
    s3_last_r  <= s2_last_r;
    s3_str_r   <= s2_str_r;
    s3_dypos_r <= s2_dypos_r;
    s3_lhs_r   <= s2_a_r * s2_dy_r;
    s3_rhs_r   <= s2_b_r * s2_c_r;
  end

  assign empty             = !out_v_r;
  assign out_word          = out_r;
  assign bk_stat.walking   = state_r != BK_IDLE;
  assign bk_stat.walk_done = walk_done;

endmodule

FILE: verif/tb_point_in_polygon_test.sv
`timescale 1ns / 1ps
// Testbench for point_in_polygon_test: loads polygons, queries points and checks every word.
// Depends on pip_pkg and the point_in_polygon_test RTL; needs no files or arguments.
module tb_point_in_polygon_test;
  import pip_pkg::*;

  localparam logic [1:0]         CMD_UNUSED  = 2'd3;
  localparam logic signed [31:0] CMIN        = 32'sh8000_0000;
  localparam logic signed [31:0] CMAX        = 32'sh7fff_ffff;
  localparam int                 LONG_STALL  = 400;
  localparam int                 QUIET_LIMIT = 20000;
  localparam int                 TAIL_CYCLES = 50;
  localparam int                 MAX_PRINTS  = 50;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_word_t  in_word = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_word_t out_word;

  in_word_t  send_q[$];
  out_word_t resp_q[$];
  out_word_t resp_head;

  logic signed [31:0] poly_x [MAX_VERTICES];
  logic signed [31:0] poly_y [MAX_VERTICES];
  int                 poly_n = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_send = 1'b0;
  int stall_req = 0;
  int stall_seen = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int mismatch_count = 0;

  point_in_polygon_test uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_word  (in_word),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
  );

  always #5 clk = ~clk;

  function automatic bit point_is_inside(logic signed [31:0] px, logic signed [31:0] py);
    bit                 in_flag;
    int                 i;
    int                 j;
    longint             xi, yi, xj, yj, dy;
    logic signed [67:0] a, b, c, d, lhs, rhs;
    in_flag = 1'b0;
    j = poly_n - 1;
    for (i = 0; i < poly_n; i++) begin
      xi = poly_x[i];
      yi = poly_y[i];
      xj = poly_x[j];
      yj = poly_y[j];
      if ((yi > py) != (yj > py)) begin
        dy = yj - yi;
        a = px - xi;
        b = dy;
        c = xj - xi;
        d = py - yi;
        lhs = a * b;
        rhs = c * d;
        if ((dy > 0) ? (lhs < rhs) : (rhs < lhs))
          in_flag = ~in_flag;
      end
      j = i;
    end
    return in_flag;
  endfunction

  function automatic out_word_t polygon_response(in_word_t w);
    out_word_t r;
    r = '0;
    case (w.command)
      CMD_CLEAR: poly_n = 0;
      CMD_APPEND: begin
        if (poly_n < MAX_VERTICES) begin
          poly_x[poly_n] = w.coord_x;
          poly_y[poly_n] = w.coord_y;
          poly_n++;
        end else begin
          r.status = ST_DROP;
        end
      end
      CMD_TEST: begin
        if (poly_n < MIN_VERTS) begin
          r.status = ST_FEW;
        end else begin
          r.inside_res = point_is_inside(w.coord_x, w.coord_y);
        end
      end
      default: ;
    endcase
    r.vertex_count = poly_n[CNT_W-1:0];
    return r;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    if (mismatch_count < MAX_PRINTS)
      $display("mismatch at %0t: %0s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        resp_q.push_back(polygon_response(in_word));
        void'(send_q.pop_front());
      end
      if (!hold_send && send_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        push    <= 1'b1;
        in_word <= send_q[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (resp_q.size() == 0) begin
          flag_mismatch("unexpected word, vertex_count", out_word.vertex_count, -1);
        end else begin
          resp_head = resp_q.pop_front();
          if (out_word.inside_res !== resp_head.inside_res)
            flag_mismatch("inside_res", out_word.inside_res, resp_head.inside_res);
          if (out_word.status !== resp_head.status)
            flag_mismatch("status", out_word.status, resp_head.status);
          if (out_word.vertex_count !== resp_head.vertex_count)
            flag_mismatch("vertex_count", out_word.vertex_count, resp_head.vertex_count);
        end
      end
      if (stall_seen != stall_req) begin
        stall_seen <= stall_req;
        stall_left <= LONG_STALL;
        pop        <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        pop        <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return 32'($urandom_range(127)) - 32'sd64;
      1: return $urandom;
      default: begin
        case ($urandom_range(4))
          0: return CMIN;
          1: return CMAX;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  task automatic queue_word(logic [1:0] cmd, logic signed [31:0] x, logic signed [31:0] y);
    in_word_t w;
    w.command = cmd;
    w.coord_x = x;
    w.coord_y = y;
    send_q.push_back(w);
  endtask

  task automatic queue_random(int items);
    int done, n, t, mode, k;
    done = 0;
    while (done < items) begin
      if ($urandom_range(99) < 80) begin
        mode = $urandom_range(2);
        n = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 3);
        if ($urandom_range(9) == 0)
          n = $urandom_range(2);
        t = $urandom_range(6, 1);
        if ($urandom_range(9) != 0)
          queue_word(CMD_CLEAR, rand_coord(1), rand_coord(1));
        for (k = 0; k < n; k++)
          queue_word(CMD_APPEND, rand_coord(mode), rand_coord(mode));
        for (k = 0; k < t; k++)
          queue_word(CMD_TEST, rand_coord(mode), rand_coord(mode));
        done += 1 + n + t;
      end else begin
        queue_word(2'($urandom_range(3)), rand_coord(1), rand_coord(1));
        done++;
      end
    end
  endtask

  task automatic wait_sent();
    while (send_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic wait_drained();
    while (send_q.size() != 0 || resp_q.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int k;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    queue_word(CMD_CLEAR, 0, 0);
    queue_word(CMD_TEST, 5, 5);
    queue_word(CMD_APPEND, 0, 0);
    queue_word(CMD_TEST, 5, 5);
    queue_word(CMD_APPEND, 10, 0);
    queue_word(CMD_TEST, 5, 5);
    queue_word(CMD_APPEND, 10, 10);
    queue_word(CMD_TEST, 8, 2);
    queue_word(CMD_APPEND, 0, 10);
    queue_word(CMD_TEST, 5, 5);
    queue_word(CMD_TEST, 10, 5);
    queue_word(CMD_TEST, 0, 5);
    queue_word(CMD_TEST, 5, 0);
    queue_word(CMD_TEST, 20, 5);
    queue_word(CMD_UNUSED, CMAX, CMIN);
    queue_word(CMD_CLEAR, CMIN, CMAX);
    queue_word(CMD_APPEND, CMIN, CMIN);
    queue_word(CMD_APPEND, CMAX, CMIN);
    queue_word(CMD_APPEND, CMAX, CMAX);
    queue_word(CMD_APPEND, CMIN, CMAX);
    queue_word(CMD_TEST, 0, 0);
    queue_word(CMD_TEST, CMIN, 0);
    queue_word(CMD_TEST, CMAX, CMAX);
    queue_word(CMD_TEST, CMIN, CMIN);
    queue_word(CMD_TEST, -1, CMAX - 1);

    // hold the receiver off while the sender keeps offering
    queue_random(120);
    stall_req++;
    wait_sent();

    // fill the store to capacity, then overflow it
    queue_word(CMD_CLEAR, 0, 0);
    for (k = 0; k < MAX_VERTICES; k++)
      queue_word(CMD_APPEND, rand_coord(0), rand_coord(0));
    for (k = 0; k < 3; k++)
      queue_word(CMD_APPEND, rand_coord(1), rand_coord(1));
    for (k = 0; k < 4; k++)
      queue_word(CMD_TEST, rand_coord(0), rand_coord(0));
    queue_word(CMD_TEST, rand_coord(1), rand_coord(1));
    queue_word(CMD_UNUSED, rand_coord(1), rand_coord(1));

    // pause the sender until every response is back
    hold_send = 1'b1;
    while (resp_q.size() != 0)
      @(negedge clk);
    hold_send = 1'b0;
    queue_random(60);
    wait_sent();

    send_idle_pct = 86;
    recv_stall_pct = 0;
    queue_random(110);
    wait_sent();

    send_idle_pct = 0;
    recv_stall_pct = 86;
    queue_random(110);
    wait_sent();

    send_idle_pct = 25;
    recv_stall_pct = 25;
    queue_random(110);

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/pip_pkg.sv
rtl/pip_front.sv
rtl/pip_fifo.sv
rtl/pip_back.sv
rtl/point_in_polygon_test.sv
verif/tb_point_in_polygon_test.sv
